// ----- rtl/core/tdcm_pkg.sv -----
// tdcm_pkg: shared types, constants and helpers of the tdc hit channel mapper
// no dependencies; imported by every module of the block
package tdcm_pkg;

    // map table geometry
    localparam int MAP_ENTRIES = 64;
    localparam int ENTRY_W     = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAP_ENTRIES + 1);

    // field widths
    localparam int SERIAL_W = 32;
    localparam int SLOT_W   = 5;
    localparam int CHAN_W   = 6;
    localparam int PLANE_W  = 4;
    localparam int GROUP_W  = 4;
    localparam int TYPE_W   = 8;
    localparam int COUNT_W  = 24;
    localparam int SHIFT_W  = 40;
    localparam int T0_W     = 32;
    localparam int NENT_W   = 7;
    localparam int WIRE_W   = 9;
    localparam int TIME_W   = 48;
    // 10*shift + count stays well inside this width
    localparam int PT_W     = 46;

    // stream packing
    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 64;

    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // apb
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam logic [1:0] REG_TDC_TYPE = 2'd0;
    localparam logic [1:0] REG_T0       = 2'd1;
    localparam logic [1:0] REG_NENT1    = 2'd2;
    localparam logic [1:0] REG_NENT2    = 2'd3;

    // input commands
    localparam logic [1:0] CMD_LOAD1 = 2'd0;
    localparam logic [1:0] CMD_LOAD2 = 2'd1;
    localparam logic [1:0] CMD_HIT   = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_MAPPED   = 2'd0;
    localparam logic [1:0] STATUS_BADTYPE  = 2'd1;
    localparam logic [1:0] STATUS_NOTFOUND = 2'd2;

    // chamber codes
    localparam logic [1:0] CHAMBER_NONE   = 2'd0;
    localparam logic [1:0] CHAMBER_FIRST  = 2'd1;
    localparam logic [1:0] CHAMBER_SECOND = 2'd2;

    // channel permutation per hptdc chip
    localparam logic [4:0] PERM_CHIP1 [32] = '{
        5'd31, 5'd15, 5'd30, 5'd14, 5'd13, 5'd29, 5'd28, 5'd12,
        5'd11, 5'd27, 5'd26, 5'd10, 5'd25, 5'd9,  5'd24, 5'd8,
        5'd23, 5'd7,  5'd22, 5'd6,  5'd21, 5'd5,  5'd20, 5'd4,
        5'd19, 5'd3,  5'd18, 5'd2,  5'd17, 5'd1,  5'd16, 5'd0
    };
    localparam logic [4:0] PERM_CHIP2 [32] = '{
        5'd31, 5'd15, 5'd30, 5'd14, 5'd29, 5'd13, 5'd28, 5'd12,
        5'd27, 5'd11, 5'd26, 5'd10, 5'd25, 5'd9,  5'd24, 5'd8,
        5'd23, 5'd7,  5'd22, 5'd6,  5'd21, 5'd5,  5'd20, 5'd4,
        5'd19, 5'd3,  5'd18, 5'd2,  5'd17, 5'd1,  5'd16, 5'd0
    };

    typedef enum logic [1:0] {
        KIND_LOAD1,
        KIND_LOAD2,
        KIND_HIT,
        KIND_BADTYPE
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [SERIAL_W-1:0] serial;
        logic [SLOT_W-1:0]   slot;
        logic [CHAN_W-1:0]   lo;
        logic [CHAN_W-1:0]   hi;
        logic [PLANE_W-1:0]  plane;
        logic [GROUP_W-1:0]  group;
    } t_map_entry;

    typedef struct packed {
        t_kind                   kind;
        logic [ENTRY_W-1:0]      idx;
        t_map_entry              entry;
        logic [CHAN_W-1:0]       ch;
        logic signed [PT_W-1:0]  ptime;
    } t_q_item;

    typedef struct packed {
        logic [TYPE_W-1:0]        tdc_type;
        logic signed [T0_W-1:0]   t0;
        logic [NENT_W-1:0]        nent1;
        logic [NENT_W-1:0]        nent2;
    } t_cfg;

    // entry matches the hit's board and the mapped channel lies in its range
    function automatic logic entry_match(t_map_entry e, logic [SERIAL_W-1:0] serial,
                                         logic [SLOT_W-1:0] slot, logic [CHAN_W-1:0] ch);
        entry_match = (e.serial == serial) && (e.slot == slot)
                    && (ch >= e.lo) && (ch <= e.hi);
    endfunction

    // group*16 + channel - low end of the entry's range, modulo the wire width
    function automatic logic [WIRE_W-1:0] wire_of(t_map_entry e, logic [CHAN_W-1:0] ch);
        wire_of = WIRE_W'({e.group, 4'b0000}) + WIRE_W'(ch) - WIRE_W'(e.lo);
    endfunction

    // entry count clipped to the table size
    function automatic logic [CNT_W-1:0] clip_count(logic [NENT_W-1:0] n);
        clip_count = (32'(n) > MAP_ENTRIES) ? CNT_W'(MAP_ENTRIES) : CNT_W'(n);
    endfunction

endpackage

// ----- rtl/core/tdcm_front.sv -----
// tdcm_front: classifies incoming items and prepares hit fields
// depends on tdcm_pkg (permutation tables, queue item type)
module tdcm_front
    import tdcm_pkg::*;
(
    input  logic                       i_valid,
    input  logic [1:0]                 i_command,
    input  logic [IN_DATA_W-1:0]       i_data,
    input  t_cfg                       i_cfg,
    output logic                       o_push,
    output t_q_item                    o_item
);

    logic [5:0]                 idx_in;
    logic [CHAN_W-1:0]          cc;
    logic [4:0]                 perm;
    logic [COUNT_W-1:0]         count;
    logic signed [SHIFT_W-1:0]  shift;
    logic signed [PT_W-1:0]     sx;
    logic signed [PT_W-1:0]     cx;
    logic                       idx_ok;

    // unpack the payload
    assign idx_in = i_data[5:0];
    assign cc     = i_data[76:71];
    assign count  = i_data[100:77];
    assign shift  = i_data[140:101];

    // chip and raw channel through the fixed permutation
    assign perm = cc[5] ? PERM_CHIP2[cc[4:0]] : PERM_CHIP1[cc[4:0]];

    // 10*shift + count, t0 is taken off at the output
    assign sx = PT_W'(shift);
    assign cx = PT_W'({1'b0, count});

    assign idx_ok = (32'(idx_in) < MAP_ENTRIES);

    always_comb begin
        o_item.idx          = ENTRY_W'(idx_in);
        o_item.entry.serial = i_data[37:6];
        o_item.entry.slot   = i_data[42:38];
        o_item.entry.lo     = i_data[48:43];
        o_item.entry.hi     = i_data[54:49];
        o_item.entry.plane  = i_data[58:55];
        o_item.entry.group  = i_data[62:59];
        o_item.ch           = {cc[5], perm};
        o_item.ptime        = (sx <<< 3) + (sx <<< 1) + cx;
        o_item.kind         = KIND_HIT;
        o_push              = 1'b0;
        case (i_command)
            CMD_LOAD1: begin
                o_item.kind = KIND_LOAD1;
                o_push      = i_valid && idx_ok;
            end
            CMD_LOAD2: begin
                o_item.kind = KIND_LOAD2;
                o_push      = i_valid && idx_ok;
            end
            CMD_HIT: begin
                o_item.kind = (i_data[70:63] == i_cfg.tdc_type) ? KIND_HIT : KIND_BADTYPE;
                o_push      = i_valid;
            end
            CMD_NONE: begin
                o_push = 1'b0;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/core/tdcm_fifo.sv -----
// tdcm_fifo: short queue of classified items between front and back
// depends on tdcm_pkg (queue item type, depth)
module tdcm_fifo
    import tdcm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_q_item  i_item,
    input  logic     i_pop,
    output logic     o_full,
    output logic     o_valid,
    output t_q_item  o_head
);

    t_q_item                 r_buf [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT_W-1:0]   r_count, n_count;
    logic                    do_push, do_pop;

    assign o_full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_buf[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointer and fill tracking
    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ----- rtl/core/tdcm_back.sv -----
// tdcm_back: map tables, sequential table search and result register
// depends on tdcm_pkg (map entry type, match and wire helpers, state enum)
module tdcm_back
    import tdcm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_head_valid,
    input  t_q_item                  i_head,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [1:0]               o_status,
    output logic [1:0]               o_chamber,
    output logic [PLANE_W-1:0]       o_plane,
    output logic [WIRE_W-1:0]        o_wire,
    output logic signed [TIME_W-1:0] o_time
);

    // map tables, undefined until loaded
    t_map_entry r_map1 [MAP_ENTRIES];
    t_map_entry r_map2 [MAP_ENTRIES];
    t_map_entry r_rd1;
    t_map_entry r_rd2;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic [CNT_W-1:0]        r_cidx, n_cidx;
    logic                    r_pend, n_pend;
    logic                    r_found2, n_found2;

    // working hit
    logic [SERIAL_W-1:0]     r_serial, n_serial;
    logic [SLOT_W-1:0]       r_slot, n_slot;
    logic [CHAN_W-1:0]       r_ch, n_ch;
    logic signed [PT_W-1:0]  r_ptime, n_ptime;

    // pending result
    logic [1:0]              r_res_status, n_res_status;
    logic [1:0]              r_res_chamber, n_res_chamber;
    logic [PLANE_W-1:0]      r_res_plane, n_res_plane;
    logic [WIRE_W-1:0]       r_res_wire, n_res_wire;
    logic [PLANE_W-1:0]      r_plane2, n_plane2;
    logic [WIRE_W-1:0]       r_wire2, n_wire2;

    // output register
    logic                    r_out_valid, n_out_valid;
    logic [1:0]              r_out_status, n_out_status;
    logic [1:0]              r_out_chamber, n_out_chamber;
    logic [PLANE_W-1:0]      r_out_plane, n_out_plane;
    logic [WIRE_W-1:0]       r_out_wire, n_out_wire;
    logic signed [TIME_W-1:0] r_out_time, n_out_time;

    logic [CNT_W-1:0]        nent1, nent2, limit;
    logic                    m1, m2, issue, out_free;
    logic                    we1, we2;
    logic [ENTRY_W-1:0]      raddr;

    assign nent1 = clip_count(i_cfg.nent1);
    assign nent2 = clip_count(i_cfg.nent2);
    assign limit = (nent1 > nent2) ? nent1 : nent2;
    assign raddr = r_idx[ENTRY_W-1:0];
    assign issue = (r_idx < limit);

    // compare the entries read in the last cycle
    assign m1 = r_pend && (r_cidx < nent1) && entry_match(r_rd1, r_serial, r_slot, r_ch);
    assign m2 = r_pend && (r_cidx < nent2) && !r_found2
              && entry_match(r_rd2, r_serial, r_slot, r_ch);

    assign out_free = !r_out_valid || i_ready;

    assign we1 = (r_state == ST_IDLE) && i_head_valid && (i_head.kind == KIND_LOAD1);
    assign we2 = (r_state == ST_IDLE) && i_head_valid && (i_head.kind == KIND_LOAD2);

    // table write and registered read
    always_ff @(posedge i_clk) begin
        if (we1) begin
            r_map1[i_head.idx] <= i_head.entry;
        end
        if (we2) begin
            r_map2[i_head.idx] <= i_head.entry;
        end
        r_rd1 <= r_map1[raddr];
        r_rd2 <= r_map2[raddr];
    end

    // sequencer: next state and outputs
    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_cidx        = r_cidx;
        n_pend        = r_pend;
        n_found2      = r_found2;
        n_serial      = r_serial;
        n_slot        = r_slot;
        n_ch          = r_ch;
        n_ptime       = r_ptime;
        n_res_status  = r_res_status;
        n_res_chamber = r_res_chamber;
        n_res_plane   = r_res_plane;
        n_res_wire    = r_res_wire;
        n_plane2      = r_plane2;
        n_wire2       = r_wire2;
        n_out_valid   = r_out_valid && !i_ready;
        n_out_status  = r_out_status;
        n_out_chamber = r_out_chamber;
        n_out_plane   = r_out_plane;
        n_out_wire    = r_out_wire;
        n_out_time    = r_out_time;
        o_pop         = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_head_valid) begin
                    o_pop    = 1'b1;
                    n_serial = i_head.entry.serial;
                    n_slot   = i_head.entry.slot;
                    n_ch     = i_head.ch;
                    n_ptime  = i_head.ptime;
                    if (i_head.kind == KIND_HIT) begin
                        n_idx    = '0;
                        n_pend   = 1'b0;
                        n_found2 = 1'b0;
                        n_state  = ST_SCAN;
                    end else if (i_head.kind == KIND_BADTYPE) begin
                        n_res_status  = STATUS_BADTYPE;
                        n_res_chamber = CHAMBER_NONE;
                        n_res_plane   = '0;
                        n_res_wire    = '0;
                        n_state       = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                n_pend = issue;
                n_cidx = r_idx;
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (m2) begin
                    n_found2 = 1'b1;
                    n_plane2 = r_rd2.plane;
                    n_wire2  = wire_of(r_rd2, r_ch);
                end
                if (m1) begin
                    // chamber 1 wins at its first match
                    n_res_status  = STATUS_MAPPED;
                    n_res_chamber = CHAMBER_FIRST;
                    n_res_plane   = r_rd1.plane;
                    n_res_wire    = wire_of(r_rd1, r_ch);
                    n_state       = ST_DONE;
                end else if (!issue && !r_pend) begin
                    n_res_status  = r_found2 ? STATUS_MAPPED : STATUS_NOTFOUND;
                    n_res_chamber = r_found2 ? CHAMBER_SECOND : CHAMBER_NONE;
                    n_res_plane   = r_found2 ? r_plane2 : '0;
                    n_res_wire    = r_found2 ? r_wire2 : '0;
                    n_state       = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_res_status;
                    n_out_chamber = r_res_chamber;
                    n_out_plane   = r_res_plane;
                    n_out_wire    = r_res_wire;
                    n_out_time    = (r_res_status == STATUS_MAPPED)
                                  ? TIME_W'(r_ptime) - TIME_W'(i_cfg.t0) : '0;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= 1'b0;
            r_found2    <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_found2    <= n_found2;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cidx        <= n_cidx;
        r_serial      <= n_serial;
        r_slot        <= n_slot;
        r_ch          <= n_ch;
        r_ptime       <= n_ptime;
        r_res_status  <= n_res_status;
        r_res_chamber <= n_res_chamber;
        r_res_plane   <= n_res_plane;
        r_res_wire    <= n_res_wire;
        r_plane2      <= n_plane2;
        r_wire2       <= n_wire2;
        r_out_status  <= n_out_status;
        r_out_chamber <= n_out_chamber;
        r_out_plane   <= n_out_plane;
        r_out_wire    <= n_out_wire;
        r_out_time    <= n_out_time;
    end

    assign o_valid   = r_out_valid;
    assign o_status  = r_out_status;
    assign o_chamber = r_out_chamber;
    assign o_plane   = r_out_plane;
    assign o_wire    = r_out_wire;
    assign o_time    = r_out_time;

endmodule

// ----- rtl/core/tdc_hit_channel_mapper_core.sv -----
// tdc hit channel mapper: a load passes through the queue and reaches its table when the back
// end is idle; a hit is searched in both tables over L entries, L the larger clipped entry
// count, and a chamber 1 match at slot k ends the search there before the result register.
// throughput: loads one per cycle while the back end is idle; a hit holds the back end for
// its search plus any output stall, set by the single read port of each map table; a 4-deep
// queue lets the input run ahead. reset: synchronous active low, clears control and
// configuration registers; map tables stay undefined until loaded, no clearing pass.
module tdc_hit_channel_mapper_core
    import tdcm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // apb configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // entry_index, crate_serial, board_slot, range_low, range_high, plane_number,
    // wire_group, hit_type, chip_channel, tdc_count, time_shift, zero pad
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    // command
    input  logic [1:0]             s_axis_tuser,
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // chamber, plane, wire_res, hit_time, zero pad
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    // status
    output logic [1:0]             m_axis_tuser
);

    t_cfg                     r_cfg;
    logic                     cfg_wr;
    logic                     push, pop, full, head_valid;
    t_q_item                  item, head;
    logic [PLANE_W-1:0]       plane;
    logic [WIRE_W-1:0]        wire_res;
    logic [1:0]               chamber;
    logic signed [TIME_W-1:0] hit_time;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_TDC_TYPE: r_cfg.tdc_type <= pwdata[TYPE_W-1:0];
                REG_T0:       r_cfg.t0       <= pwdata[T0_W-1:0];
                REG_NENT1:    r_cfg.nent1    <= pwdata[NENT_W-1:0];
                REG_NENT2:    r_cfg.nent2    <= pwdata[NENT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[3:2])
            REG_TDC_TYPE: prdata = APB_DATA_W'(r_cfg.tdc_type);
            REG_T0:       prdata = APB_DATA_W'(r_cfg.t0);
            REG_NENT1:    prdata = APB_DATA_W'(r_cfg.nent1);
            REG_NENT2:    prdata = APB_DATA_W'(r_cfg.nent2);
            default:      prdata = '0;
        endcase
    end

    // front: classify each transfer
    assign s_axis_tready = !full;

    tdcm_front u_front (
        .i_valid   (s_axis_tvalid && s_axis_tready),
        .i_command (s_axis_tuser),
        .i_data    (s_axis_tdata),
        .i_cfg     (r_cfg),
        .o_push    (push),
        .o_item    (item)
    );

    tdcm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (item),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_head  (head)
    );

    // back: table writes, search and result
    tdcm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_status     (m_axis_tuser),
        .o_chamber    (chamber),
        .o_plane      (plane),
        .o_wire       (wire_res),
        .o_time       (hit_time)
    );

    assign m_axis_tdata = {1'b0, hit_time, wire_res, plane, chamber};

endmodule

// ----- rtl/core/tdcm_checker.sv -----
// tdcm_checker: port-level assertions on the result stream
// depends on tdcm_pkg; bound to tdc_hit_channel_mapper_core
module tdcm_checker
    import tdcm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [1:0]            m_axis_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // rejected or unmapped hits carry zero fields
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != STATUS_MAPPED |-> m_axis_tdata == '0)
        else $error("unmapped result with nonzero fields");

    // mapped hits name chamber 1 or 2
    a_chamber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == STATUS_MAPPED
            |-> m_axis_tdata[1:0] == CHAMBER_FIRST || m_axis_tdata[1:0] == CHAMBER_SECOND)
        else $error("mapped result without chamber");

    // no result right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind tdc_hit_channel_mapper_core tdcm_checker u_tdcm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
